[design/callsite_cfi_edge_checker_defines.svh]
// assertion macros shared by the checker
// no dependencies
`ifndef CALLSITE_CFI_EDGE_CHECKER_DEFINES_SVH
`define CALLSITE_CFI_EDGE_CHECKER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CCEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CCEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/ccec_pkg.sv]
// package for the call-site edge checker: types and codes
// no dependencies
package ccec_pkg;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  localparam logic [2:0] V_CTX    = 3'd0;
  localparam logic [2:0] V_STATIC = 3'd1;
  localparam logic [2:0] V_VIOL   = 3'd2;
  localparam logic [2:0] V_INS    = 3'd3;
  localparam logic [2:0] V_FULL   = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WT, S_WALK, S_ENT_WT, S_CMP, S_INS_WR,
    S_DONE
  } state_t;
endpackage

[design/ccec_ram.sv]
// generic single-port-write ram with registered read
// no dependencies
module ccec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/callsite_cfi_edge_checker.sv]
// top level of the call-site edge checker: sequencer, bucket and entry stores
// depends on ccec_pkg and ccec_ram
//
// Each request (start high while busy low) is served alone. An insert
// hashes, reads the bucket head, writes entry and head, then gives its
// result. A check walks its bucket chain, then the static chain, one entry
// at a time (registered ram read, then compare), as the entry store has a
// single read port. A check at a context level that misses its own chain
// makes a second pass for the static chain; a level-zero check makes only
// that pass. After reset a clearing pass writes every bucket head empty,
// one per cycle, while busy stays high. The result shows on out_verdict for
// one cycle with out_valid; the receiver cannot stall it.
module callsite_cfi_edge_checker #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_level,
  input  logic [63:0] in_branch_point,
  input  logic [63:0] in_branch_target,
  input  logic [63:0] in_caller_one,
  input  logic [63:0] in_caller_two,
  input  logic [63:0] in_caller_three,
  output logic        out_valid,
  output logic [2:0]  out_verdict
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1); // pointer, ENTRIES = end of chain
  localparam int RW = 3 + 64 * 5 + PW;     // entry record width
  localparam logic [PW-1:0] NO_ENTRY = PW'(ENTRIES);

  ccec_pkg::state_t state_r, state_nxt;

  // latched request, callers beyond depth zeroed
  logic        op_r;
  logic [2:0]  lvl_r;
  logic [63:0] pt_r, tg_r, s1_r, s2_r, s3_r;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic          pass_r, pass_nxt;       // 0 context pass, 1 static pass
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] used_r, used_nxt;
  logic [PW:0]   steps_r, steps_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic [2:0]    verd_r, verd_nxt;
  logic [2:0]    lvl_c;

  // bucket head memory
  logic          h_we;
  logic [BW-1:0] h_waddr, h_raddr;
  logic [PW-1:0] h_wdata, h_rdata;
  // entry pool memory
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [RW-1:0] e_wdata, e_rdata;

  ccec_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );
  ccec_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_pool (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  // compare key for the current pass
  logic [RW-PW-1:0] key;
  logic             hit;
  always_comb begin
    if (pass_r) key = {3'd0, pt_r, tg_r, 64'd0, 64'd0, 64'd0};
    else        key = {lvl_r, pt_r, tg_r, s1_r, s2_r, s3_r};
    hit = (e_rdata[RW-1:PW] == key);
  end

  always_comb begin
    lvl_c = (in_level > 3'd4) ? 3'd4 : in_level;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_op;
      lvl_r <= lvl_c;
      pt_r  <= in_branch_point;
      tg_r  <= in_branch_target;
      s1_r  <= (lvl_c < 3'd2) ? 64'd0 : in_caller_one;
      s2_r  <= (lvl_c < 3'd3) ? 64'd0 : in_caller_two;
      s3_r  <= (lvl_c < 3'd4) ? 64'd0 : in_caller_three;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccec_pkg::S_CLEAR;
      used_r  <= '0;
      clr_r   <= '0;
      verd_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      clr_r   <= clr_nxt;
      verd_r  <= verd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bkt_r   <= bkt_nxt;
    pass_r  <= pass_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
  end

  logic [63:0] hkey;
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    clr_nxt   = clr_r;
    verd_nxt  = verd_r;
    bkt_nxt   = bkt_r;
    pass_nxt  = pass_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    h_we = 1'b0; h_waddr = bkt_r; h_wdata = NO_ENTRY; h_raddr = bkt_r;
    e_we = 1'b0; e_waddr = used_r[EW-1:0]; e_raddr = cur_r[EW-1:0];
    e_wdata = {lvl_r, pt_r, tg_r, s1_r, s2_r, s3_r, h_rdata};
    hkey = pass_r ? (pt_r ^ tg_r) : (pt_r ^ tg_r ^ s1_r ^ s2_r ^ s3_r);
    case (state_r)
      ccec_pkg::S_CLEAR: begin
        h_we = 1'b1; h_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == BUCKETS - 1) state_nxt = ccec_pkg::S_IDLE;
      end
      ccec_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = ccec_pkg::S_HASH;
          pass_nxt  = (in_op == ccec_pkg::OP_CHECK) && (in_level == 3'd0);
        end
      end
      ccec_pkg::S_HASH: begin
        bkt_nxt   = BW'(hkey % 64'(BUCKETS));
        steps_nxt = '0;
        if (op_r == ccec_pkg::OP_INSERT && 32'(used_r) >= ENTRIES) begin
          verd_nxt = ccec_pkg::V_FULL; state_nxt = ccec_pkg::S_DONE;
        end else begin
          state_nxt = ccec_pkg::S_HEAD_RD;
        end
      end
      ccec_pkg::S_HEAD_RD: state_nxt = ccec_pkg::S_HEAD_WT;
      ccec_pkg::S_HEAD_WT: begin
        if (op_r == ccec_pkg::OP_INSERT) begin
          state_nxt = ccec_pkg::S_INS_WR;
        end else begin
          cur_nxt = h_rdata; state_nxt = ccec_pkg::S_WALK;
        end
      end
      ccec_pkg::S_INS_WR: begin
        e_we = 1'b1;
        h_we = 1'b1; h_wdata = used_r;
        used_nxt = used_r + 1'b1;
        verd_nxt = ccec_pkg::V_INS; state_nxt = ccec_pkg::S_DONE;
      end
      ccec_pkg::S_WALK: begin
        if (cur_r < used_r && 32'(steps_r) < ENTRIES) begin
          state_nxt = ccec_pkg::S_ENT_WT;
        end else if (!pass_r) begin
          pass_nxt = 1'b1; state_nxt = ccec_pkg::S_HASH;
        end else begin
          verd_nxt = ccec_pkg::V_VIOL; state_nxt = ccec_pkg::S_DONE;
        end
      end
      ccec_pkg::S_ENT_WT: state_nxt = ccec_pkg::S_CMP;
      ccec_pkg::S_CMP: begin
        if (hit) begin
          verd_nxt  = pass_r ? ccec_pkg::V_STATIC : ccec_pkg::V_CTX;
          state_nxt = ccec_pkg::S_DONE;
        end else begin
          cur_nxt   = e_rdata[PW-1:0];
          steps_nxt = steps_r + 1'b1;
          state_nxt = ccec_pkg::S_WALK;
        end
      end
      ccec_pkg::S_DONE: state_nxt = ccec_pkg::S_IDLE;
      default: state_nxt = ccec_pkg::S_IDLE;
    endcase
  end

  assign busy        = (state_r != ccec_pkg::S_IDLE);
  assign out_valid   = (state_r == ccec_pkg::S_DONE);
  assign out_verdict = verd_r;
endmodule

[design/ccec_checker.sv]
// port-level checker for the call-site edge checker, bound to the top level
// depends on callsite_cfi_edge_checker_defines.svh
`include "callsite_cfi_edge_checker_defines.svh"
module ccec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_verdict
);
  // a result always lands while busy and frees the block next cycle
  `CCEC_ASSERT_IMP(a_res_busy, out_valid, busy)
  `CCEC_ASSERT_NXT(a_res_free, out_valid, !busy && !out_valid)
  // an accepted request makes the block busy
  `CCEC_ASSERT_NXT(a_acc_busy, start && !busy, busy)
  // verdict codes stay in range
  `CCEC_ASSERT_IMP(a_verd, out_valid, out_verdict <= 3'd4)
endmodule

bind callsite_cfi_edge_checker ccec_checker u_ccec_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_verdict
);

[tb/sv/tb_callsite_cfi_edge_checker.sv]
// testbench for the call-site edge checker: drives insert and check requests,
// predicts each verdict from its own copy of the edge table and compares
// depends on ccec_pkg and the callsite_cfi_edge_checker top level
`timescale 1ns / 1ps

module tb_callsite_cfi_edge_checker;

  localparam int NBUCKET = 1024;
  localparam int NENTRY  = 4096;
  localparam int RANDOM_REQS = 1870;

  typedef struct {
    logic        op;
    logic [2:0]  level;
    logic [63:0] point;
    logic [63:0] target;
    logic [63:0] c1;
    logic [63:0] c2;
    logic [63:0] c3;
    bit          drain;   // wait for every verdict before this request
  } edge_req_t;

  typedef struct packed {
    logic [2:0]  level;
    logic [63:0] point;
    logic [63:0] target;
    logic [63:0] c1;
    logic [63:0] c2;
    logic [63:0] c3;
  } edge_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [2:0]  in_level;
  logic [63:0] in_branch_point;
  logic [63:0] in_branch_target;
  logic [63:0] in_caller_one;
  logic [63:0] in_caller_two;
  logic [63:0] in_caller_three;
  logic        out_valid;
  logic [2:0]  out_verdict;

  edge_req_t   pending_reqs[$];
  logic [2:0]  verdicts_due[$];
  edge_t       allowed_edges[$];   // predictor's edge table (order never matters)
  edge_t       known_edges[$];     // inserted tuples, reused for matching checks
  int          errors;
  int          gap_left;

  callsite_cfi_edge_checker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_level(in_level),
    .in_branch_point(in_branch_point), .in_branch_target(in_branch_target),
    .in_caller_one(in_caller_one), .in_caller_two(in_caller_two),
    .in_caller_three(in_caller_three),
    .out_valid(out_valid), .out_verdict(out_verdict)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // fold the level and clear callers beyond its depth
  function automatic edge_t normalise(edge_req_t r);
    edge_t e;
    e.level = (r.level > 3'd4) ? 3'd4 : r.level;
    e.point = r.point;
    e.target = r.target;
    e.c1 = (e.level < 3'd2) ? 64'd0 : r.c1;
    e.c2 = (e.level < 3'd3) ? 64'd0 : r.c2;
    e.c3 = (e.level < 3'd4) ? 64'd0 : r.c3;
    return e;
  endfunction

  function automatic bit table_holds(edge_t e);
    foreach (allowed_edges[i])
      if (allowed_edges[i] == e) return 1'b1;
    return 1'b0;
  endfunction

  // predicted verdict of one request, updating the table on insert
  function automatic logic [2:0] verdict_of(edge_req_t r);
    edge_t e;
    edge_t s;
    e = normalise(r);
    if (r.op == ccec_pkg::OP_INSERT) begin
      if (allowed_edges.size() >= NENTRY) return ccec_pkg::V_FULL;
      allowed_edges.push_back(e);
      return ccec_pkg::V_INS;
    end
    if (e.level != 3'd0 && table_holds(e)) return ccec_pkg::V_CTX;
    s = '{3'd0, e.point, e.target, 64'd0, 64'd0, 64'd0};
    if (table_holds(s)) return ccec_pkg::V_STATIC;
    return ccec_pkg::V_VIOL;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic edge_req_t mk(logic op, logic [2:0] lvl, logic [63:0] p, logic [63:0] t,
                                   logic [63:0] a, logic [63:0] b, logic [63:0] c);
    edge_req_t r;
    r = '{op, lvl, p, t, a, b, c, 1'b0};
    return r;
  endfunction

  // driver: one request per accepting edge, gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start <= 1'b0;
      gap_left <= pick_gap();
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain && verdicts_due.size() > 0)) begin
        edge_req_t r;
        r = pending_reqs.pop_front();
        verdicts_due.push_back(verdict_of(r));
        start <= 1'b1;
        in_op <= r.op;
        in_level <= r.level;
        in_branch_point <= r.point;
        in_branch_target <= r.target;
        in_caller_one <= r.c1;
        in_caller_two <= r.c2;
        in_caller_three <= r.c3;
      end
    end
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict %0d", out_verdict);
        errors++;
      end else begin
        logic [2:0] want;
        want = verdicts_due.pop_front();
        if (out_verdict !== want) begin
          $error("verdict: expected %0d, actual %0d", want, out_verdict);
          errors++;
        end
      end
    end
  end

  initial begin
    edge_req_t r;
    edge_t k;
    int sel;
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = 1'b0;
    in_level = 3'd0;
    in_branch_point = '0;
    in_branch_target = '0;
    in_caller_one = '0;
    in_caller_two = '0;
    in_caller_three = '0;

    // directed: empty table, extremes, every level, fold above four, static fallback
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd7, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd0, 64'h10, 64'h20, '1, '1, '1));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd0, 64'h10, 64'h20, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd3, 64'h10, 64'h20, 64'h5, 64'h6,
                              64'h7));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd1, '1, '0, '1, '1, '1));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd1, '1, '0, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd2, 64'hA, 64'hB, 64'hC, '1, '1));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd2, 64'hA, 64'hB, 64'hC, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd2, 64'hA, 64'hB, 64'hD, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd3, '1, '1, '1, '1, 64'h3));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd3, '1, '1, '1, '1, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd6, 64'h1, 64'h2, 64'h3, 64'h4,
                              64'h5));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd4, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd5, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd7, 64'h1, 64'h2, 64'h3, 64'h4, 64'h6));
    // duplicate insert, then a colliding bucket (same xor)
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd0, 64'h10, 64'h20, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd0, 64'h30, 64'h0, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd0, 64'h30, 64'h0, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd0, 64'h20, 64'h10, '0, '0, '0));
    known_edges.push_back('{3'd0, 64'h10, 64'h20, 64'h0, 64'h0, 64'h0});
    known_edges.push_back('{3'd2, 64'hA, 64'hB, 64'hC, 64'h0, 64'h0});
    known_edges.push_back('{3'd4, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5});

    // random: small address pool so checks hit, raw 64-bit noise elsewhere
    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(0, 99);
      r.level = 3'($urandom_range(0, 7));
      if (sel < 35 || known_edges.size() == 0) begin
        r.op = ccec_pkg::OP_INSERT;
        if ($urandom_range(0, 3) == 0) begin
          r.point = rand64(); r.target = rand64();
        end else begin
          r.point = 64'($urandom_range(0, 15)); r.target = 64'($urandom_range(0, 15));
        end
        r.c1 = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 3));
        r.c2 = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 3));
        r.c3 = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 3));
        k = normalise(r);
        known_edges.push_back(k);
      end else if (sel < 75) begin
        // check of a known tuple, sometimes at a different level or caller
        k = known_edges[$urandom_range(0, known_edges.size() - 1)];
        r.op = ccec_pkg::OP_CHECK;
        r.level = (k.level == 3'd4 && $urandom_range(0, 1)) ? 3'($urandom_range(4, 7)) : k.level;
        r.point = k.point; r.target = k.target;
        r.c1 = k.c1; r.c2 = k.c2; r.c3 = k.c3;
        if ($urandom_range(0, 3) == 0) r.level = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 5) == 0) r.c1 = r.c1 ^ 64'd1;
        if (r.level < 3'd4) r.c3 = rand64();   // unused callers are ignored
      end else begin
        r.op = ccec_pkg::OP_CHECK;
        r.point = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 15));
        r.target = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 15));
        r.c1 = rand64(); r.c2 = rand64(); r.c3 = rand64();
      end
      r.drain = (i == RANDOM_REQS / 2);
      pending_reqs.push_back(r);
    end

    // a last insert and checks of early tuples after the random run
    pending_reqs.push_back(mk(ccec_pkg::OP_INSERT, 3'd0, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd0, 64'h10, 64'h20, '0, '0, '0));
    pending_reqs.push_back(mk(ccec_pkg::OP_CHECK, 3'd4, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !start);
    wait (verdicts_due.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // bound holds even if every check walked every stored entry twice
  initial begin
    #2s;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
